// ----- design/sha256_pkg.sv -----
// shared types, constants and sigma functions for the sha-256 digest block
// no dependencies; used by every module in this folder
`timescale 1ns / 1ps

package sha256_pkg;

   typedef struct packed {
      logic load;     // copy chain hash into working registers
      logic round;    // run one compression round
      logic finish;   // add working registers into chain hash
      logic rotate;   // rotate chain hash toward word zero for output
      logic init;     // restore initial hash values
   } core_cmd_type;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_FILL_POS  = 6'd56;
   localparam logic [5:0] LAST_FILL_POS = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ----- design/sha256_msg_buf.sv -----
// message block buffer: packs bytes big-endian into words and rolls the
// sixteen-word schedule window; depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_msg_buf (
   input  logic        clock,
   input  logic        put_en,
   input  logic [1:0]  put_pos,
   input  logic [7:0]  put_data,
   input  logic        sched_en,
   output logic [31:0] w_head
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [23:0] asm_ff;
   logic [23:0] asm_in;
   logic [31:0] w_next;

   // w_ff[0] holds W[t], the window slides one word per round
   assign w_next = sha256_pkg::small_sigma1(w_ff[14]) + w_ff[9]
                 + sha256_pkg::small_sigma0(w_ff[1]) + w_ff[0];
   assign w_head = w_ff[0];

   always_comb begin
      asm_in = asm_ff;
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (put_en) begin
         // older bytes fall off the top, so each word starts clean
         asm_in = {asm_ff[15:0], put_data};
         if (put_pos == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = {asm_ff, put_data};
         end
      end else if (sched_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_next;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

endmodule

// ----- design/sha256_round_core.sv -----
// compression round unit: working registers a..h, one round per cycle while
// cmd.round is set, and the chain hash; depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_round_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::core_cmd_type  cmd,
   input  logic [31:0]               w_t,
   input  logic [5:0]                round_idx,
   output logic [31:0]               digest_word
);

   logic [31:0] work_ff  [8];
   logic [31:0] work_in  [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + sha256_pkg::big_sigma1(work_ff[4]) + ch
              + sha256_pkg::ROUND_K[round_idx] + w_t;
   assign t2  = sha256_pkg::big_sigma0(work_ff[0]) + maj;
   assign digest_word = chain_ff[0];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         work_in[i]  = work_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < 8; i++) begin
            work_in[i] = chain_ff[i];
         end
      end else if (cmd.round) begin
         for (int i = 1; i < 8; i++) begin
            work_in[i] = work_ff[i - 1];
         end
         work_in[4] = work_ff[3] + t1;
         work_in[0] = t1 + t2;
      end
      if (cmd.init) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = sha256_pkg::INIT_HASH[i];
         end
      end else if (cmd.finish) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end else if (cmd.rotate) begin
         for (int i = 0; i < 7; i++) begin
            chain_in[i] = chain_ff[i + 1];
         end
         chain_in[7] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::INIT_HASH[i];
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

endmodule

// ----- design/sha256_message_digest.sv -----
// sha-256 digest of a byte stream: sequencer, byte count and padding
// depends on sha256_pkg, sha256_msg_buf and sha256_round_core
`timescale 1ns / 1ps

// Usage
//   req channel: one message byte per transfer. tdata carries the byte,
//   tuser marks it as present (0 = empty item), tlast ends the message.
//   An item with tuser and tlast both low is taken and does nothing.
//   rsp channel: after tlast the eight digest words leave in order, H0
//   first; tuser holds the word index and tlast marks the eighth word.
// Timing
//   One byte is taken per cycle while req_tready is high. The transfer
//   that fills a 64-byte block starts a compression: 64 rounds in the
//   shared round unit, then an add into the chain hash, with req_tready
//   low. At the end of a message the pad bytes go through the same byte
//   path, one per cycle outside compressions (0x80, zeros up to byte 56,
//   a switch step, eight length bytes), then one or two compressions
//   and the eight result words, one per cycle while rsp_tready is high.
//   A stalled receiver simply holds the current word; nothing is lost.
// Reset
//   Synchronous reset restores the initial hash, clears the byte count
//   and leaves the block ready for a new message. After the last word
//   transfers the block re-initializes the same way by itself.

module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_COMP,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   state_type   after_put;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [60:0] total_ff, total_in;
   logic [2:0]  word_ff, word_in;

   logic        req_xfer;
   logic        rsp_xfer;
   logic        put_en;
   logic [7:0]  put_data;
   logic [63:0] bit_len;
   logic [2:0]  len_sel;
   logic        sched_en;
   logic [31:0] w_head;
   sha256_pkg::core_cmd_type core_cmd;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tuser  = word_ff;
   assign rsp_tlast  = (word_ff == sha256_pkg::LAST_WORD_IDX);

   assign bit_len = {total_ff, 3'b000};
   assign len_sel = 3'd7 - fill_ff[2:0];
   assign sched_en = (state_ff == ST_COMP);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      round_in  = round_ff;
      total_in  = total_ff;
      word_in   = word_ff;
      put_en    = 1'b0;
      put_data  = 8'h00;
      after_put = state_ff;
      core_cmd  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  put_en   = 1'b1;
                  put_data = req_tdata;
                  total_in = total_ff + 61'd1;
               end
               after_put = req_tlast ? ST_MARK : ST_IDLE;
               state_in  = after_put;
            end
         end
         ST_MARK: begin
            put_en    = 1'b1;
            put_data  = sha256_pkg::PAD_MARK_BYTE;
            after_put = ST_ZERO;
            state_in  = ST_ZERO;
         end
         ST_ZERO: begin
            if (fill_ff == sha256_pkg::LEN_FILL_POS) begin
               state_in = ST_LEN;
            end else begin
               put_en = 1'b1;
            end
         end
         ST_LEN: begin
            put_en    = 1'b1;
            put_data  = bit_len[{len_sel, 3'b000} +: 8];
            after_put = ST_OUT;
         end
         ST_COMP: begin
            core_cmd.round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            core_cmd.finish = 1'b1;
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               core_cmd.rotate = 1'b1;
               word_in = word_ff + 3'd1;
               if (word_ff == sha256_pkg::LAST_WORD_IDX) begin
                  core_cmd.rotate = 1'b0;
                  core_cmd.init   = 1'b1;
                  total_in = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (put_en) begin
         fill_in = fill_ff + 6'd1;
         // a full block starts compression, then resumes where it left off
         if (fill_ff == sha256_pkg::LAST_FILL_POS) begin
            core_cmd.load = 1'b1;
            round_in = '0;
            ret_in   = after_put;
            state_in = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         total_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         total_ff <= total_in;
         word_ff  <= word_in;
      end
   end

   sha256_msg_buf u_msg_buf (
      .clock    (clock),
      .put_en   (put_en),
      .put_pos  (fill_ff[1:0]),
      .put_data (put_data),
      .sched_en (sched_en),
      .w_head   (w_head)
   );

   sha256_round_core u_round_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (core_cmd),
      .w_t         (w_head),
      .round_idx   (round_ff),
      .digest_word (rsp_tdata)
   );

   // compression only ever starts on a block boundary
   a_comp_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMP |-> fill_ff == '0)
      else $error("compression running with a partly filled block");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && round_ff == sha256_pkg::LAST_ROUND) |=> state_ff == ST_FIN)
      else $error("compression did not finish after the last round");

   a_len_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN && fill_ff == sha256_pkg::LAST_FILL_POS)
         |=> (state_ff == ST_COMP && ret_ff == ST_OUT))
      else $error("length block not followed by final compression");

   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (req_tready && total_ff == '0 && fill_ff == '0))
      else $error("block not re-initialized after the last digest word");

endmodule
